>>> rtl/scr_pkg.sv
// ---------------------------------------------------------------------------
// scr_pkg: shared definitions for the serial command recognizer
// Character codes, result kinds and sizes used by the interfaces, the text
// decoder and the top level.
// ---------------------------------------------------------------------------
package scr_pkg;

    localparam int CHAR_W      = 8;
    localparam int KIND_W      = 3;
    localparam int VALUE_W     = 7;
    localparam int TEXT_LEN    = 3;
    localparam int COUNT_W     = 2;
    localparam int CNT_W       = 8;

    localparam logic [CHAR_W-1:0] CHAR_HASH = 8'h23;   // '#'
    localparam logic [CHAR_W-1:0] CHAR_BANG = 8'h21;   // '!'
    localparam logic [CHAR_W-1:0] CHAR_C    = 8'h43;   // 'C'
    localparam logic [CHAR_W-1:0] CHAR_N    = 8'h4E;   // 'N'
    localparam logic [CHAR_W-1:0] CHAR_E    = 8'h45;   // 'E'
    localparam logic [CHAR_W-1:0] CHAR_W_UC = 8'h57;   // 'W'
    localparam logic [CHAR_W-1:0] CHAR_D    = 8'h44;   // 'D'
    localparam logic [CHAR_W-1:0] CHAR_0    = 8'h30;   // '0'
    localparam logic [CHAR_W-1:0] CHAR_9    = 8'h39;   // '9'
    localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;

    localparam logic [COUNT_W-1:0] TEXT_FULL   = 2'd3;
    localparam logic [CNT_W-1:0]   COUNT_LIMIT = 8'd5;

    typedef enum logic [KIND_W-1:0] {
        KIND_START  = 3'd0,
        KIND_PLAY   = 3'd1,
        KIND_NEW    = 3'd2,
        KIND_END    = 3'd3,
        KIND_IGNORE = 3'd4
    } kind_t;

    typedef logic [TEXT_LEN-1:0][CHAR_W-1:0] text_t;

endpackage

>>> rtl/scr_if.sv
// ---------------------------------------------------------------------------
// scr_if: valid/ready channels of the serial command recognizer
// scr_char_if carries received characters, scr_result_if carries results.
// ---------------------------------------------------------------------------
interface scr_char_if;
    logic                       valid;
    logic                       ready;
    logic [scr_pkg::CHAR_W-1:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface scr_result_if;
    logic                        valid;
    logic                        ready;
    logic [scr_pkg::KIND_W-1:0]  kind;
    logic [scr_pkg::VALUE_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

>>> rtl/scr_decode.sv
// ---------------------------------------------------------------------------
// scr_decode: command text decoder
// Maps the three stored characters to play / new game / end game / ignore.
// ---------------------------------------------------------------------------
module scr_decode
(
    input  scr_pkg::text_t              text,
    output scr_pkg::kind_t              kind,
    output logic [scr_pkg::VALUE_W-1:0] value
);

    logic [scr_pkg::CHAR_W-1:0]  a;
    logic [scr_pkg::CHAR_W-1:0]  b;
    logic [scr_pkg::CHAR_W-1:0]  c;
    logic                        b_digit;
    logic                        c_digit;
    logic [scr_pkg::VALUE_W-1:0] b_val;
    logic [scr_pkg::VALUE_W-1:0] c_val;

    assign a = text[0];
    assign b = text[1];
    assign c = text[2];

    assign b_digit = (b >= scr_pkg::CHAR_0) && (b <= scr_pkg::CHAR_9);
    assign c_digit = (c >= scr_pkg::CHAR_0) && (c <= scr_pkg::CHAR_9);

    // ASCII digits: low nibble is the digit value
    assign b_val = {3'b000, b[3:0]};
    assign c_val = {3'b000, c[3:0]};

    always_comb
    begin
        kind  = scr_pkg::KIND_IGNORE;
        value = '0;
        if (a == scr_pkg::CHAR_C && b_digit && c == scr_pkg::CHAR_NUL)
        begin
            kind  = scr_pkg::KIND_PLAY;
            value = b_val;
        end
        else if (a == scr_pkg::CHAR_C && b_digit && c_digit)
        begin
            kind  = scr_pkg::KIND_PLAY;
            value = (b_val << 3) + (b_val << 1) + c_val;   // b*10 + c
        end
        else if (a == scr_pkg::CHAR_N && b == scr_pkg::CHAR_E && c == scr_pkg::CHAR_W_UC)
        begin
            kind = scr_pkg::KIND_NEW;
        end
        else if (a == scr_pkg::CHAR_E && b == scr_pkg::CHAR_N && c == scr_pkg::CHAR_D)
        begin
            kind = scr_pkg::KIND_END;
        end
    end

endmodule

>>> rtl/serial_command_recognizer_unit.sv
// ---------------------------------------------------------------------------
// serial_command_recognizer_unit: command recognizer for a received stream
// Path: an accepted character is held in the input register, and its result
//   is loaded into the result register, which drives cmd.
// Throughput: one character per cycle; ready falls only when a result is
//   blocked in the result register and the staged character has one too.
// Reset (rst_n low, async): not reading, empty text, counter zero, both
//   stages empty.
// ---------------------------------------------------------------------------
module serial_command_recognizer_unit
(
    input  logic                clk,
    input  logic                rst_n,
    scr_char_if.sink            rx,
    scr_result_if.source        cmd
);

    // ---- input stage ----
    logic                              s1_valid_reg;
    logic [scr_pkg::CHAR_W-1:0]        s1_char_reg;

    // ---- recognizer state ----
    logic                              reading_reg;
    logic                              reading_next;
    logic [scr_pkg::COUNT_W-1:0]       count_reg;
    logic [scr_pkg::COUNT_W-1:0]       count_next;
    scr_pkg::text_t                    text_reg;
    scr_pkg::text_t                    text_next;
    logic [scr_pkg::CNT_W-1:0]         cnt_reg;
    logic [scr_pkg::CNT_W-1:0]         cnt_next;

    // ---- result stage ----
    logic                              out_valid_reg;
    logic                              out_valid_next;
    scr_pkg::kind_t                    out_kind_reg;
    scr_pkg::kind_t                    out_kind_next;
    logic [scr_pkg::VALUE_W-1:0]       out_value_reg;
    logic [scr_pkg::VALUE_W-1:0]       out_value_next;

    // ---- step logic ----
    logic                              is_hash;
    logic                              is_bang;
    logic                              has_result;
    logic                              out_load_ok;
    logic                              s1_done;
    logic                              s1_free;
    scr_pkg::kind_t                    dec_kind;
    logic [scr_pkg::VALUE_W-1:0]       dec_value;
    scr_pkg::kind_t                    res_kind;
    logic [scr_pkg::VALUE_W-1:0]       res_value;

    // Decode always looks at the stored text; used only when '!' ends a command.
    scr_decode u_decode
    (
        .text  (text_reg),
        .kind  (dec_kind),
        .value (dec_value)
    );

    assign is_hash = (s1_char_reg == scr_pkg::CHAR_HASH);
    // '!' outside a command is an ordinary character
    assign is_bang = reading_reg && (s1_char_reg == scr_pkg::CHAR_BANG);

    // State update for the staged character
    always_comb
    begin
        reading_next = reading_reg;
        count_next   = count_reg;
        text_next    = text_reg;
        if (is_hash)
        begin
            reading_next = 1'b1;
            count_next   = '0;
            text_next    = '0;
        end
        else if (is_bang)
        begin
            reading_next = 1'b0;
        end
        else if (reading_reg)
        begin
            if (count_reg == scr_pkg::TEXT_FULL)
            begin
                // overlong command: drop the character, stop reading
                reading_next = 1'b0;
            end
            else
            begin
                text_next[count_reg] = s1_char_reg;
                count_next           = count_reg + 2'd1;
            end
        end
    end

    // '#' and a command-ending '!' restart the counter at one; all else counts up
    assign cnt_next = (is_hash || is_bang) ? 8'd1 : cnt_reg + 8'd1;

    always_comb
    begin
        res_kind  = scr_pkg::KIND_IGNORE;
        res_value = '0;
        if (is_hash)
        begin
            res_kind = scr_pkg::KIND_START;
        end
        else if (is_bang)
        begin
            res_kind  = dec_kind;
            res_value = dec_value;
        end
    end

    // Too many characters without a command boundary also yields ignore
    assign has_result = is_hash || is_bang || (cnt_next > scr_pkg::COUNT_LIMIT);

    // Result register takes a new item when empty or being drained
    assign out_load_ok = !out_valid_reg || cmd.ready;
    // A staged character without a result never waits on the output side
    assign s1_done     = s1_valid_reg && (!has_result || out_load_ok);
    assign s1_free     = !s1_valid_reg || s1_done;
    assign rx.ready    = s1_free;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_value_next = out_value_reg;
        if (out_load_ok)
        begin
            out_valid_next = s1_valid_reg && has_result;
            out_kind_next  = res_kind;
            out_value_next = res_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            reading_reg   <= 1'b0;
            count_reg     <= '0;
            text_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= rx.valid;
            end
            if (s1_done)
            begin
                reading_reg <= reading_next;
                count_reg   <= count_next;
                text_reg    <= text_next;
                cnt_reg     <= cnt_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s1_free && rx.valid)
        begin
            s1_char_reg <= rx.char_in;
        end
        out_kind_reg  <= out_kind_next;
        out_value_reg <= out_value_next;
    end

    assign cmd.valid = out_valid_reg;
    assign cmd.kind  = out_kind_reg;
    assign cmd.value = out_value_reg;

endmodule
